// ----- design/tgpg_pkg.sv -----
// ----------------------------------------------------------------------------
// tgpg_pkg
// shared types, constants and the 6x6 glyph rom of the text glyph generator
// ----------------------------------------------------------------------------
package tgpg_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;

  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int GLYPH_BITS = 36;
  localparam int CELL       = 6;

  localparam logic [7:0] CODE_NEWLINE = 8'h0A;
  localparam logic [7:0] CODE_FIRST   = 8'h20;
  localparam logic [7:0] CODE_LAST    = 8'h5F;

  localparam logic REQ_CHAR   = 1'b0;
  localparam logic REQ_CURSOR = 1'b1;

  typedef enum logic [1:0] {
    CFG_FG_COLOR    = 2'd0,
    CFG_BG_COLOR    = 2'd1,
    CFG_SCALE       = 2'd2,
    CFG_WRAP_ENABLE = 2'd3
  } cfg_idx_t;

  // one drawable character handed from front to back
  typedef struct packed {
    logic [15:0]           x;
    logic [15:0]           y;
    logic [GLYPH_BITS-1:0] mask;
    logic [7:0]            side;
    logic [1:0]            fg;
    logic [1:0]            bg;
    logic                  draw_bg;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [31:0] glyph_rom(input logic [5:0] idx);
    logic [31:0] g;
    unique case (idx)
      6'd0:  g = 32'h00000000;  6'd1:  g = 32'h00017000;
      6'd2:  g = 32'h000C00C0;  6'd3:  g = 32'h0A7CA7CA;
      6'd4:  g = 32'h0855F542;  6'd5:  g = 32'h19484253;
      6'd6:  g = 32'h1251F55E;  6'd7:  g = 32'h00003000;
      6'd8:  g = 32'h00452700;  6'd9:  g = 32'h001C9440;
      6'd10: g = 32'h0519F314;  6'd11: g = 32'h0411F104;
      6'd12: g = 32'h00000420;  6'd13: g = 32'h04104104;
      6'd14: g = 32'h00000400;  6'd15: g = 32'h01084210;
      6'd16: g = 32'h0F45145E;  6'd17: g = 32'h0001F040;
      6'd18: g = 32'h13555559;  6'd19: g = 32'h0D5D5551;
      6'd20: g = 32'h087C928C;  6'd21: g = 32'h0D555557;
      6'd22: g = 32'h0D55555E;  6'd23: g = 32'h010C5251;
      6'd24: g = 32'h0F55555E;  6'd25: g = 32'h0F555556;
      6'd26: g = 32'h0000A000;  6'd27: g = 32'h0000A400;
      6'd28: g = 32'h0028C200;  6'd29: g = 32'h0028A280;
      6'd30: g = 32'h00086280;  6'd31: g = 32'h000D5040;
      6'd32: g = 32'h0018E300;  6'd33: g = 32'h1F24929C;
      6'd34: g = 32'h0D5D555F;  6'd35: g = 32'h1145149C;
      6'd36: g = 32'h0725145F;  6'd37: g = 32'h1155555F;
      6'd38: g = 32'h0114515F;  6'd39: g = 32'h1D55545E;
      6'd40: g = 32'h1F10411F;  6'd41: g = 32'h0045F440;
      6'd42: g = 32'h07210410;  6'd43: g = 32'h1D18411F;
      6'd44: g = 32'h1041041F;  6'd45: g = 32'h1F04F05E;
      6'd46: g = 32'h1F04109C;  6'd47: g = 32'h0F45545E;
      6'd48: g = 32'h0314925F;  6'd49: g = 32'h1F45D45E;
      6'd50: g = 32'h1B34925F;  6'd51: g = 32'h0D555556;
      6'd52: g = 32'h0105F041;  6'd53: g = 32'h0721041F;
      6'd54: g = 32'h0108421F;  6'd55: g = 32'h0F41E41F;
      6'd56: g = 32'h1D184317;  6'd57: g = 32'h0109C107;
      6'd58: g = 32'h114D5651;  6'd59: g = 32'h0045F000;
      6'd60: g = 32'h0001F000;  6'd61: g = 32'h0001F440;
      6'd62: g = 32'h000C1080;  6'd63: g = 32'h10410410;
    endcase
    return g;
  endfunction

endpackage

// ----- design/tgpg_front.sv -----
// ----------------------------------------------------------------------------
// tgpg_front
// takes requests, keeps cursor and colour registers, queues drawable glyphs
// ----------------------------------------------------------------------------
module tgpg_front #(
  parameter int SCREEN_WIDTH  = tgpg_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tgpg_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [7:0]        char_code,
  input  logic [15:0]       new_x,
  input  logic [15:0]       new_y,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  tgpg_pkg::q_stat_t q_stat,
  output logic              push,
  output tgpg_pkg::job_t    push_job
);
  import tgpg_pkg::*;

  localparam logic signed [17:0] WIDTH_S  = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] HEIGHT_S = 18'(SCREEN_HEIGHT);

  logic [1:0]  fg_color;
  logic [1:0]  bg_color;
  logic [7:0]  scale;
  logic        wrap_enable;
  logic [15:0] cursor_col;
  logic [15:0] cursor_row;
  logic [15:0] cursor_col_next;
  logic [15:0] cursor_row_next;

  logic               accept;
  logic [7:0]         s;
  logic [10:0]        s5;
  logic [10:0]        s6;
  logic signed [17:0] x_ext;
  logic signed [17:0] y_ext;
  logic signed [17:0] s5_ext;
  logic signed [17:0] s6_ext;
  logic signed [17:0] col_adv_ext;
  logic               printable;
  logic               visible;
  logic               draw_bg;
  logic [7:0]         code_off;
  logic [31:0]        bits;
  logic [15:0]        col_adv;
  logic [15:0]        row_nl;
  logic               wrap_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;

  // scale zero behaves as one
  assign s  = (scale == 8'd0) ? 8'd1 : scale;
  assign s5 = ({3'b0, s} << 2) + {3'b0, s};
  assign s6 = ({3'b0, s} << 2) + ({3'b0, s} << 1);

  assign x_ext  = 18'($signed(cursor_col));
  assign y_ext  = 18'($signed(cursor_row));
  assign s5_ext = $signed({7'b0, s5});
  assign s6_ext = $signed({7'b0, s6});

  assign printable = (char_code >= CODE_FIRST) && (char_code <= CODE_LAST);
  assign visible   = !((x_ext >= WIDTH_S) || (y_ext >= HEIGHT_S) ||
                       ((x_ext + s5_ext) < 18'sd0) || ((y_ext + s6_ext) < 18'sd0));
  assign draw_bg   = (bg_color != fg_color);
  assign code_off  = char_code - CODE_FIRST;
  assign bits      = glyph_rom(code_off[5:0]);

  assign col_adv     = cursor_col + {5'b0, s6};
  assign row_nl      = cursor_row + {5'b0, s6};
  assign col_adv_ext = 18'($signed(col_adv));
  assign wrap_hit    = wrap_enable && (col_adv_ext > (WIDTH_S - s6_ext));

  // blank glyphs with a transparent background produce no squares
  assign push = accept && (req_type == REQ_CHAR) && printable && visible &&
                ((bits != 32'd0) || draw_bg);

  always_comb begin
    push_job.x       = cursor_col;
    push_job.y       = cursor_row;
    push_job.mask    = {4'b0, bits};
    push_job.side    = s;
    push_job.fg      = fg_color;
    push_job.bg      = bg_color;
    push_job.draw_bg = draw_bg;
  end

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    if (accept) begin
      if (req_type == REQ_CURSOR) begin
        cursor_col_next = new_x;
        cursor_row_next = new_y;
      end else if (char_code == CODE_NEWLINE) begin
        cursor_col_next = 16'd0;
        cursor_row_next = row_nl;
      end else if (printable) begin
        if (wrap_hit) begin
          cursor_col_next = 16'd0;
          cursor_row_next = row_nl;
        end else begin
          cursor_col_next = col_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color    <= 2'd1;
      bg_color    <= 2'd0;
      scale       <= 8'd1;
      wrap_enable <= 1'b1;
      cursor_col  <= 16'd0;
      cursor_row  <= 16'd0;
    end else begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FG_COLOR:    fg_color    <= cfg_data[1:0];
          CFG_BG_COLOR:    bg_color    <= cfg_data[1:0];
          CFG_SCALE:       scale       <= cfg_data;
          CFG_WRAP_ENABLE: wrap_enable <= cfg_data[0];
        endcase
      end
    end
  end

endmodule

// ----- design/tgpg_queue.sv -----
// ----------------------------------------------------------------------------
// tgpg_queue
// short fifo of glyph jobs between the request front and the square back
// ----------------------------------------------------------------------------
module tgpg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tgpg_pkg::job_t    push_job,
  input  logic              pop,
  output tgpg_pkg::job_t    head,
  output tgpg_pkg::q_stat_t q_stat
);
  import tgpg_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head         = mem[rd_ptr];
  assign q_stat.count = count;
  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/tgpg_back.sv -----
// ----------------------------------------------------------------------------
// tgpg_back
// walks one glyph column by column, at most one square per cycle unless stalled
// ----------------------------------------------------------------------------
module tgpg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  tgpg_pkg::job_t job,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [15:0]    rect_x,
  output logic [15:0]    rect_y,
  output logic [7:0]     rect_side,
  output logic [1:0]     pixel_color,
  output logic           last
);
  import tgpg_pkg::*;

  logic                  active;
  logic [GLYPH_BITS-1:0] mask;
  logic [5:0]            step;
  logic [2:0]            row_cnt;
  logic [15:0]           cur_x;
  logic [15:0]           cur_y;
  logic [15:0]           y0;
  logic [7:0]            side;
  logic [1:0]            fg;
  logic [1:0]            bg;
  logic                  draw_bg;

  logic adv;
  logic on;
  logic emit;
  logic fire;
  logic finish;

  assign pop    = !active && job_valid;
  assign adv    = active && (!out_valid || !out_stall);
  assign on     = mask[0];
  assign emit   = on || draw_bg;
  assign fire   = adv && emit;
  // without background the last square is the highest set bit
  assign finish = draw_bg ? (step == 6'(GLYPH_BITS - 1)) : (mask[GLYPH_BITS-1:1] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        active  <= 1'b1;
        mask    <= job.mask;
        step    <= 6'd0;
        row_cnt <= 3'd0;
        cur_x   <= job.x;
        cur_y   <= job.y;
        y0      <= job.y;
        side    <= job.side;
        fg      <= job.fg;
        bg      <= job.bg;
        draw_bg <= job.draw_bg;
      end else if (adv) begin
        if (emit) begin
          rect_x      <= cur_x;
          rect_y      <= cur_y;
          rect_side   <= side;
          pixel_color <= on ? fg : bg;
          last        <= finish;
        end
        mask <= mask >> 1;
        step <= step + 6'd1;
        if (row_cnt == 3'(CELL - 1)) begin
          row_cnt <= 3'd0;
          cur_y   <= y0;
          cur_x   <= cur_x + {8'b0, side};
        end else begin
          row_cnt <= row_cnt + 3'd1;
          cur_y   <= cur_y + {8'b0, side};
        end
        if (finish) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- design/text_glyph_pixel_generator.sv -----
// ----------------------------------------------------------------------------
// text_glyph_pixel_generator
// 6x6 bitmap font character generator, up to one scaled square per unstalled cycle
// ----------------------------------------------------------------------------
// first square: with the walker idle, a request goes into the glyph queue, then
//   into the walker, then onto the output registers; skipped clear bits delay it
// flow: one request per cycle into a 2-deep glyph queue while it is not full; the
//   walker loads a job and steps through all 36 bits with a background colour,
//   or to its highest set bit without; at most one square per cycle, held on stall
// reset: synchronous, clears cursor, queue and output; colour fg 1, bg 0,
//   scale 1, wrap on
module text_glyph_pixel_generator #(
  parameter int SCREEN_WIDTH  = tgpg_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tgpg_pkg::DEF_SCREEN_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  char_code,
  input  logic [15:0] new_x,
  input  logic [15:0] new_y,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] rect_x,
  output logic [15:0] rect_y,
  output logic [7:0]  rect_side,
  output logic [1:0]  pixel_color,
  output logic        last
);
  import tgpg_pkg::*;

  q_stat_t q_stat;
  job_t    push_job;
  job_t    head;
  logic    push;
  logic    pop;

  tgpg_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .char_code(char_code),
    .new_x    (new_x),
    .new_y    (new_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  tgpg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  tgpg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (!q_stat.empty),
    .job        (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .rect_x     (rect_x),
    .rect_y     (rect_y),
    .rect_side  (rect_side),
    .pixel_color(pixel_color),
    .last       (last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_stat.count != QCNT_W'(QDEPTH)))
    else $error("glyph queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (q_stat.count != '0))
    else $error("glyph queue underflow");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && (q_stat.count == '0)))
    else $error("reset left output or queue busy");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count did not follow push");

endmodule
